// ===== rtl/bdb_pkg.sv =====
// shared types, sizes and codes of the b-spline de boor evaluator
// no dependencies
`default_nettype none
package bdb_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_ORDER  = 8;
  localparam int KNOT_DEPTH = MAX_POINTS + MAX_ORDER;

  localparam int VAL_W  = 32;
  localparam int CP_AW  = $clog2(MAX_POINTS);
  localparam int KT_AW  = $clog2(KNOT_DEPTH);
  localparam int WP_AW  = $clog2(MAX_ORDER);
  localparam int ORD_W  = 4;
  localparam int CNT_W  = 7;
  localparam int DEG_W  = 3;

  // magnitude divider: 2|num|+|den| over 2|den|
  localparam int DIV_NUM_W = 53;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [2:0] OP_LOAD_POINT = 3'd0;
  localparam logic [2:0] OP_LOAD_KNOT  = 3'd1;
  localparam logic [2:0] OP_VALUE      = 3'd2;
  localparam logic [2:0] OP_DERIV1     = 3'd3;
  localparam logic [2:0] OP_DERIV2     = 3'd4;

  localparam logic [1:0] KIND_VALUE  = 2'd0;
  localparam logic [1:0] KIND_DERIV1 = 2'd1;
  localparam logic [1:0] KIND_DERIV2 = 2'd2;

  localparam logic [1:0] STEP_FIRST  = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;
  localparam logic [1:0] STEP_OUTER  = 2'd2;

  localparam logic [3:0] REG_ORDER = 4'd0;
  localparam logic [3:0] REG_COUNT = 4'd1;

  localparam logic [ORD_W-1:0] ORDER_RESET = 4'd4;
  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd4;

  typedef enum logic [1:0] {A_CP, A_KT, A_WP, A_Q0} a_src_t;
  typedef enum logic [1:0] {B_CP, B_WP, B_RES, B_X} b_src_t;

  typedef struct packed {
    logic [CP_AW-1:0] cp_addr;
    logic [KT_AW-1:0] kt_addr;
    logic [WP_AW-1:0] wp_raddr;
    logic [WP_AW-1:0] wp_waddr;
    logic             wp_we;
    logic             wp_from_cp;
    logic             st_cp_we;
    logic             st_kt_we;
    logic             ld_x;
    logic             clr_sat;
    logic             ld_a;
    a_src_t           a_src;
    logic             ld_b;
    b_src_t           b_src;
    logic             ld_lo;
    logic             ld_hi;
    logic             ld_q0;
    logic             ld_alpha;
    logic             div_start;
    logic [DEG_W-1:0] div_mul;
    logic             mul_lo;
    logic             mul_hi;
    logic             mul_sum;
    logic             lerp_fin;
    logic             emit;
    logic             emit_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic op_done;
    logic knot_less;
  } dp_stat_t;

  typedef enum logic [28:0] {
    S_IDLE = 29'h1 << 0,
    S_SCHK = 29'h1 << 1,
    S_SCMP = 29'h1 << 2,
    S_GINI = 29'h1 << 3,
    S_G0A  = 29'h1 << 4,
    S_G0B  = 29'h1 << 5,
    S_DA   = 29'h1 << 6,
    S_DB   = 29'h1 << 7,
    S_DC   = 29'h1 << 8,
    S_DS   = 29'h1 << 9,
    S_DW   = 29'h1 << 10,
    S_DN   = 29'h1 << 11,
    S_BINI = 29'h1 << 12,
    S_AA   = 29'h1 << 13,
    S_AB   = 29'h1 << 14,
    S_AC   = 29'h1 << 15,
    S_AS   = 29'h1 << 16,
    S_AW   = 29'h1 << 17,
    S_AN   = 29'h1 << 18,
    S_LA   = 29'h1 << 19,
    S_LB   = 29'h1 << 20,
    S_L1   = 29'h1 << 21,
    S_L2   = 29'h1 << 22,
    S_L3   = 29'h1 << 23,
    S_L4   = 29'h1 << 24,
    S_LW   = 29'h1 << 25,
    S_FA   = 29'h1 << 26,
    S_FB   = 29'h1 << 27,
    S_ZERO = 29'h1 << 28
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/bdb_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on bdb_pkg
`default_nettype none
module bdb_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bdb_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [bdb_pkg::DIV_DEN_W-1:0] den,
  output logic                               done,
  output logic [bdb_pkg::DIV_NUM_W-1:0]      quo
);

  logic [bdb_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [bdb_pkg::DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [bdb_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          run_r, done_r;
  logic [bdb_pkg::DIV_DEN_W:0]   trial, diff;
  logic                          ge;

  always_comb begin
    trial   = {rem_r, quo_r[bdb_pkg::DIV_NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[bdb_pkg::DIV_DEN_W-1:0] : trial[bdb_pkg::DIV_DEN_W-1:0];
    quo_nxt = {quo_r[bdb_pkg::DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bdb_pkg::DIV_CNT_W'(bdb_pkg::DIV_NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/bdb_dp.sv =====
// datapath: point, knot and work stores, operand registers, quotient and blend
// depends on bdb_pkg and bdb_div
`default_nettype none
module bdb_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire bdb_pkg::dp_cmd_t                 cmd,
  input  wire logic [6:0]                       in_slot,
  input  wire logic signed [bdb_pkg::VAL_W-1:0] in_value,
  output bdb_pkg::dp_stat_t                     stat,
  output logic signed [bdb_pkg::VAL_W-1:0]      out_value,
  output logic                                  out_sat
);

  logic signed [31:0] cp_mem [bdb_pkg::MAX_POINTS];
  logic signed [31:0] kt_mem [bdb_pkg::KNOT_DEPTH];
  logic signed [31:0] wp_mem [bdb_pkg::MAX_ORDER];
  logic signed [31:0] cp_q, kt_q, wp_q;

  logic signed [31:0] x_r, a_r, b_r, lo_r, hi_r, q0_r, res_r, alpha_r;
  logic signed [31:0] out_value_r;
  logic               out_sat_r, sat_r, zdone_r, neg_r;

  logic signed [49:0] pl_r;
  logic signed [48:0] ph_r;
  logic signed [64:0] prod_r;

  // quotient set-up
  logic signed [32:0] ddiff, den;
  logic signed [36:0] dprod;
  logic signed [52:0] num;
  logic [52:0]        nmag;
  logic [32:0]        dmag;
  logic [bdb_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic [bdb_pkg::DIV_DEN_W-1:0] div_den;
  logic               den_zero, div_go, div_done;

  // quotient result
  logic signed [31:0] qres;
  logic               qclip;

  // blend
  logic signed [64:0] rnd;
  logic signed [48:0] sh;
  logic signed [49:0] bsum;
  logic signed [31:0] bres;
  logic               bclip;

  always_ff @(posedge clk) begin
    if (cmd.st_cp_we) cp_mem[in_slot[bdb_pkg::CP_AW-1:0]] <= in_value;
    cp_q <= cp_mem[cmd.cp_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.st_kt_we) kt_mem[in_slot[bdb_pkg::KT_AW-1:0]] <= in_value;
    kt_q <= kt_mem[cmd.kt_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wp_we) wp_mem[cmd.wp_waddr] <= cmd.wp_from_cp ? cp_q : res_r;
    wp_q <= wp_mem[cmd.wp_raddr];
  end

  always_comb begin
    ddiff    = $signed({b_r[31], b_r}) - $signed({a_r[31], a_r});
    dprod    = ddiff * $signed({1'b0, cmd.div_mul});
    num      = {dprod, 16'b0};
    nmag     = num[52] ? 53'(-num) : 53'(num);
    den      = $signed({hi_r[31], hi_r}) - $signed({lo_r[31], lo_r});
    dmag     = den[32] ? 33'(-den) : 33'(den);
    den_zero = (den == '0);
    div_num  = {nmag[51:0], 1'b0} + {20'b0, dmag};
    div_den  = {dmag[31:0], 1'b0};
    div_go   = cmd.div_start && !den_zero;
  end

  bdb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    if (neg_r) begin
      qclip = (div_quo[52:32] != '0) || (div_quo[31] && (div_quo[30:0] != '0));
      qres  = qclip ? 32'sh8000_0000 : 32'(-div_quo[31:0]);
    end else begin
      qclip = (div_quo[52:31] != '0);
      qres  = qclip ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
    end
  end

  always_comb begin
    rnd   = prod_r + (prod_r[64] ? 65'sd32767 : 65'sd32768);
    sh    = rnd[64:16];
    bsum  = $signed({sh[48], sh}) + $signed({{18{a_r[31]}}, a_r});
    bclip = (bsum[49:31] != '0) && (bsum[49:31] != '1);
    if (!bclip)       bres = bsum[31:0];
    else if (bsum[49]) bres = 32'sh8000_0000;
    else              bres = 32'sh7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zdone_r   <= 1'b0;
      sat_r     <= 1'b0;
      out_sat_r <= 1'b0;
    end else begin
      zdone_r <= cmd.div_start && den_zero;
      if (cmd.clr_sat) sat_r <= 1'b0;
      else if ((div_done && qclip) || (cmd.lerp_fin && bclip)) sat_r <= 1'b1;
      if (cmd.emit) out_sat_r <= cmd.emit_zero ? 1'b0 : sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_x) x_r <= in_value;
    if (cmd.ld_a) begin
      case (cmd.a_src)
        bdb_pkg::A_CP: a_r <= cp_q;
        bdb_pkg::A_KT: a_r <= kt_q;
        bdb_pkg::A_WP: a_r <= wp_q;
        bdb_pkg::A_Q0: a_r <= q0_r;
        default:       a_r <= cp_q;
      endcase
    end
    if (cmd.ld_b) begin
      case (cmd.b_src)
        bdb_pkg::B_CP:  b_r <= cp_q;
        bdb_pkg::B_WP:  b_r <= wp_q;
        bdb_pkg::B_RES: b_r <= res_r;
        bdb_pkg::B_X:   b_r <= x_r;
        default:        b_r <= cp_q;
      endcase
    end
    if (cmd.ld_lo)    lo_r    <= kt_q;
    if (cmd.ld_hi)    hi_r    <= kt_q;
    if (cmd.ld_q0)    q0_r    <= res_r;
    if (cmd.ld_alpha) alpha_r <= res_r;
    if (cmd.div_start) neg_r  <= num[52] ^ den[32];
    if (cmd.div_start && den_zero) res_r <= '0;
    else if (div_done)    res_r <= qres;
    else if (cmd.lerp_fin) res_r <= bres;
    if (cmd.mul_lo)  pl_r   <= ddiff * $signed({1'b0, alpha_r[15:0]});
    if (cmd.mul_hi)  ph_r   <= ddiff * $signed(alpha_r[31:16]);
    if (cmd.mul_sum) prod_r <= $signed({ph_r, 16'b0}) + $signed({{15{pl_r[49]}}, pl_r});
    if (cmd.emit)    out_value_r <= cmd.emit_zero ? 32'sd0 : wp_q;
  end

  assign stat.op_done   = div_done || zdone_r;
  assign stat.knot_less = (kt_q < x_r);
  assign out_value      = out_value_r;
  assign out_sat        = out_sat_r;

endmodule
`default_nettype wire

// ===== rtl/bdb_ctrl.sv =====
// sequencer: configuration registers, span search, point forming, de boor loop
// depends on bdb_pkg
`default_nettype none
module bdb_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [2:0]                  opcode,
  input  wire logic [6:0]                  slot,
  input  wire logic                        cfg_valid,
  input  wire logic [3:0]                  cfg_index,
  input  wire logic [6:0]                  cfg_data,
  input  wire bdb_pkg::dp_stat_t           stat,
  output bdb_pkg::dp_cmd_t                 cmd,
  output logic                             busy,
  output logic                             out_strobe,
  output logic [1:0]                       out_kind
);

  bdb_pkg::state_t state_r, state_nxt;
  logic [bdb_pkg::ORD_W-1:0] ord_r;
  logic [bdb_pkg::CNT_W-1:0] cnt_r;
  logic [1:0] level_r, level_nxt, step_r, step_nxt;
  logic [6:0] lk_r, lk_nxt;
  logic [3:0] m_r, m_nxt;
  logic [2:0] j_r, j_nxt, r_r, r_nxt, i_r, i_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;

  logic [3:0] ke, m_calc;
  logic [6:0] ne, lp, g, base, ia, ib, tl, th, alo, ahi;
  logic       accept, is_eval;

  always_comb begin
    if (ord_r < 4'd2)                                ke = 4'd2;
    else if (ord_r > 4'(bdb_pkg::MAX_ORDER))         ke = 4'(bdb_pkg::MAX_ORDER);
    else                                             ke = ord_r;
    ne     = (cnt_r > 7'(bdb_pkg::MAX_POINTS)) ? 7'(bdb_pkg::MAX_POINTS) : cnt_r;
    lp     = lk_r - 7'(ke) + 7'd1;
    g      = lp + 7'(j_r);
    base   = lk_r - 7'(m_r) + 7'd2;
    alo    = base + 7'(i_r) - 7'd1;
    ahi    = base + 7'(i_r) + 7'(m_r) - 7'(r_r) - 7'd1;
    m_calc = ke - 4'(level_r);
    accept = start && (state_r == bdb_pkg::S_IDLE);
    is_eval = (opcode == bdb_pkg::OP_VALUE) || (opcode == bdb_pkg::OP_DERIV1) ||
              (opcode == bdb_pkg::OP_DERIV2);
    case (step_r)
      bdb_pkg::STEP_FIRST: begin
        ia = g; ib = g + 7'd1; tl = g + 7'd1; th = g + 7'(ke);
      end
      bdb_pkg::STEP_SECOND: begin
        ia = g + 7'd1; ib = g + 7'd2; tl = g + 7'd2; th = g + 7'(ke) + 7'd1;
      end
      default: begin
        ia = g; ib = g; tl = g + 7'd2; th = g + 7'(ke);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    step_nxt      = step_r;
    lk_nxt        = lk_r;
    m_nxt         = m_r;
    j_nxt         = j_r;
    r_nxt         = r_r;
    i_nxt         = i_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    cmd           = '0;
    cmd.st_cp_we  = accept && (opcode == bdb_pkg::OP_LOAD_POINT) &&
                    (slot < 7'(bdb_pkg::MAX_POINTS));
    cmd.st_kt_we  = accept && (opcode == bdb_pkg::OP_LOAD_KNOT) &&
                    (slot < 7'(bdb_pkg::KNOT_DEPTH));
    cmd.div_mul   = (step_r == bdb_pkg::STEP_OUTER) ? 3'(ke - 4'd2) : 3'(ke - 4'd1);
    case (state_r)
      bdb_pkg::S_IDLE: begin
        if (accept && is_eval) begin
          cmd.ld_x    = 1'b1;
          cmd.clr_sat = 1'b1;
          level_nxt   = 2'(opcode - bdb_pkg::OP_VALUE);
          lk_nxt      = 7'(ke) - 7'd1;
          state_nxt   = (ne < 7'(ke)) ? bdb_pkg::S_ZERO : bdb_pkg::S_SCHK;
        end
      end
      bdb_pkg::S_SCHK: begin
        cmd.kt_addr = lk_r + 7'd1;
        state_nxt   = (lk_r < ne - 7'd1) ? bdb_pkg::S_SCMP : bdb_pkg::S_GINI;
      end
      bdb_pkg::S_SCMP: begin
        if (stat.knot_less) begin
          lk_nxt    = lk_r + 7'd1;
          state_nxt = bdb_pkg::S_SCHK;
        end else begin
          state_nxt = bdb_pkg::S_GINI;
        end
      end
      bdb_pkg::S_GINI: begin
        m_nxt    = m_calc;
        j_nxt    = '0;
        step_nxt = bdb_pkg::STEP_FIRST;
        if (m_calc == '0)                       state_nxt = bdb_pkg::S_ZERO;
        else if (level_r == bdb_pkg::KIND_VALUE) state_nxt = bdb_pkg::S_G0A;
        else                                    state_nxt = bdb_pkg::S_DA;
      end
      bdb_pkg::S_G0A: begin
        cmd.cp_addr = g[bdb_pkg::CP_AW-1:0];
        state_nxt   = bdb_pkg::S_G0B;
      end
      bdb_pkg::S_G0B: begin
        cmd.wp_we      = 1'b1;
        cmd.wp_from_cp = 1'b1;
        cmd.wp_waddr   = j_r;
        if (4'(j_r) == m_r - 4'd1) state_nxt = bdb_pkg::S_BINI;
        else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = bdb_pkg::S_G0A;
        end
      end
      bdb_pkg::S_DA: begin
        cmd.cp_addr = ia[bdb_pkg::CP_AW-1:0];
        cmd.kt_addr = tl;
        state_nxt   = bdb_pkg::S_DB;
      end
      bdb_pkg::S_DB: begin
        cmd.ld_a    = 1'b1;
        cmd.a_src   = (step_r == bdb_pkg::STEP_OUTER) ? bdb_pkg::A_Q0 : bdb_pkg::A_CP;
        cmd.ld_lo   = 1'b1;
        cmd.cp_addr = ib[bdb_pkg::CP_AW-1:0];
        cmd.kt_addr = th;
        state_nxt   = bdb_pkg::S_DC;
      end
      bdb_pkg::S_DC: begin
        cmd.ld_b  = 1'b1;
        cmd.b_src = (step_r == bdb_pkg::STEP_OUTER) ? bdb_pkg::B_RES : bdb_pkg::B_CP;
        cmd.ld_hi = 1'b1;
        state_nxt = bdb_pkg::S_DS;
      end
      bdb_pkg::S_DS: begin
        cmd.div_start = 1'b1;
        state_nxt     = bdb_pkg::S_DW;
      end
      bdb_pkg::S_DW: begin
        if (stat.op_done) state_nxt = bdb_pkg::S_DN;
      end
      bdb_pkg::S_DN: begin
        if (level_r == bdb_pkg::KIND_DERIV2 && step_r == bdb_pkg::STEP_FIRST) begin
          cmd.ld_q0 = 1'b1;
          step_nxt  = bdb_pkg::STEP_SECOND;
          state_nxt = bdb_pkg::S_DA;
        end else if (level_r == bdb_pkg::KIND_DERIV2 &&
                     step_r == bdb_pkg::STEP_SECOND) begin
          step_nxt  = bdb_pkg::STEP_OUTER;
          state_nxt = bdb_pkg::S_DA;
        end else begin
          cmd.wp_we    = 1'b1;
          cmd.wp_waddr = j_r;
          step_nxt     = bdb_pkg::STEP_FIRST;
          if (4'(j_r) == m_r - 4'd1) state_nxt = bdb_pkg::S_BINI;
          else begin
            j_nxt     = j_r + 3'd1;
            state_nxt = bdb_pkg::S_DA;
          end
        end
      end
      bdb_pkg::S_BINI: begin
        r_nxt     = 3'd1;
        i_nxt     = 3'(m_r - 4'd1);
        state_nxt = (m_r == 4'd1) ? bdb_pkg::S_FA : bdb_pkg::S_AA;
      end
      bdb_pkg::S_AA: begin
        cmd.kt_addr = alo;
        state_nxt   = bdb_pkg::S_AB;
      end
      bdb_pkg::S_AB: begin
        cmd.ld_lo   = 1'b1;
        cmd.ld_a    = 1'b1;
        cmd.a_src   = bdb_pkg::A_KT;
        cmd.ld_b    = 1'b1;
        cmd.b_src   = bdb_pkg::B_X;
        cmd.kt_addr = ahi;
        state_nxt   = bdb_pkg::S_AC;
      end
      bdb_pkg::S_AC: begin
        cmd.ld_hi = 1'b1;
        state_nxt = bdb_pkg::S_AS;
      end
      bdb_pkg::S_AS: begin
        cmd.div_start = 1'b1;
        cmd.div_mul   = 3'd1;
        state_nxt     = bdb_pkg::S_AW;
      end
      bdb_pkg::S_AW: begin
        if (stat.op_done) state_nxt = bdb_pkg::S_AN;
      end
      bdb_pkg::S_AN: begin
        cmd.ld_alpha = 1'b1;
        cmd.wp_raddr = i_r - 3'd1;
        state_nxt    = bdb_pkg::S_LA;
      end
      bdb_pkg::S_LA: begin
        cmd.ld_a     = 1'b1;
        cmd.a_src    = bdb_pkg::A_WP;
        cmd.wp_raddr = i_r;
        state_nxt    = bdb_pkg::S_LB;
      end
      bdb_pkg::S_LB: begin
        cmd.ld_b  = 1'b1;
        cmd.b_src = bdb_pkg::B_WP;
        state_nxt = bdb_pkg::S_L1;
      end
      bdb_pkg::S_L1: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = bdb_pkg::S_L2;
      end
      bdb_pkg::S_L2: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = bdb_pkg::S_L3;
      end
      bdb_pkg::S_L3: begin
        cmd.mul_sum = 1'b1;
        state_nxt   = bdb_pkg::S_L4;
      end
      bdb_pkg::S_L4: begin
        cmd.lerp_fin = 1'b1;
        state_nxt    = bdb_pkg::S_LW;
      end
      bdb_pkg::S_LW: begin
        cmd.wp_we    = 1'b1;
        cmd.wp_waddr = i_r;
        if (i_r == r_r) begin
          if (4'(r_r) == m_r - 4'd1) state_nxt = bdb_pkg::S_FA;
          else begin
            r_nxt     = r_r + 3'd1;
            i_nxt     = 3'(m_r - 4'd1);
            state_nxt = bdb_pkg::S_AA;
          end
        end else begin
          i_nxt     = i_r - 3'd1;
          state_nxt = bdb_pkg::S_AA;
        end
      end
      bdb_pkg::S_FA: begin
        cmd.wp_raddr = 3'(m_r - 4'd1);
        state_nxt    = bdb_pkg::S_FB;
      end
      bdb_pkg::S_FB: begin
        cmd.emit      = 1'b1;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = level_r;
        state_nxt     = bdb_pkg::S_IDLE;
      end
      bdb_pkg::S_ZERO: begin
        cmd.emit      = 1'b1;
        cmd.emit_zero = 1'b1;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = level_r;
        state_nxt     = bdb_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bdb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdb_pkg::S_IDLE;
      ord_r       <= bdb_pkg::ORDER_RESET;
      cnt_r       <= bdb_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_index == bdb_pkg::REG_ORDER) ord_r <= cfg_data[3:0];
      if (cfg_valid && cfg_index == bdb_pkg::REG_COUNT) cnt_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    level_r    <= level_nxt;
    step_r     <= step_nxt;
    lk_r       <= lk_nxt;
    m_r        <= m_nxt;
    j_r        <= j_nxt;
    r_r        <= r_nxt;
    i_r        <= i_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign busy       = (state_r != bdb_pkg::S_IDLE);
  assign out_strobe = out_valid_r;
  assign out_kind   = out_kind_r;

endmodule
`default_nettype wire

// ===== rtl/bspline_deboor_eval_unit.sv =====
// top level of the b-spline de boor evaluator: sequencer plus datapath
// depends on bdb_pkg, bdb_ctrl, bdb_dp
//
// channel  direction  handshake               beat
// in_      in         start & !busy           opcode, slot_index, operand_value
// out_     out        out_strobe, one cycle   result_value, result_kind, saturated
// cfg_     in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// a load is stored when it is accepted; an evaluation steps through the knot span search,
// forms the value points or derivative quotients (53 divider steps; one quotient per first
// and three per second derivative point), then runs m(m-1)/2 blends for
// m = order minus derivative level; busy stays high throughout. reset is synchronous,
// active low: order 4, 4 points, stores undefined until loaded. the result strobe
// cannot be stalled; cfg_ready is always high.
`default_nettype none
module bspline_deboor_eval_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_opcode,
  input  wire logic [6:0]         in_slot_index,
  input  wire logic signed [31:0] in_operand_value,
  output logic                    out_strobe,
  output logic signed [31:0]      out_result_value,
  output logic [1:0]              out_result_kind,
  output logic                    out_saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [6:0]         cfg_data
);

  bdb_pkg::dp_cmd_t  cmd;
  bdb_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bdb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .opcode     (in_opcode),
    .slot       (in_slot_index),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_kind   (out_result_kind)
  );

  bdb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_slot   (in_slot_index),
    .in_value  (in_operand_value),
    .stat      (stat),
    .out_value (out_result_value),
    .out_sat   (out_saturated)
  );

endmodule
`default_nettype wire
